>>> src/ray_triangle_intersect_core_macros.svh
// Assertion macros shared by the ray/triangle intersection RTL.
// Included by the queue and the top level; no other dependencies.
`ifndef RAY_TRIANGLE_INTERSECT_CORE_MACROS_SVH
`define RAY_TRIANGLE_INTERSECT_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RTI_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rti assertion failed");

// next-cycle implication, disabled while in reset
`define RTI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rti assertion failed");

`endif

>>> src/rti_pkg.sv
// Shared constants, register codes and width helpers for the ray/triangle core.
// No dependencies.
`default_nettype none

package rti_pkg;

    localparam int DIR_W      = 21;   // direction, signed Q4.16
    localparam int DIR_FRAC   = 16;
    localparam int COORD_FRAC = 8;
    localparam int DIST_W     = 30;   // distance, unsigned Q14.16
    localparam int QDEPTH     = 4;
    localparam int MIN_DIST_RST = 7;

    typedef enum logic [1:0] {
        REG_VERTEX_A = 2'd0,
        REG_VERTEX_B = 2'd1,
        REG_VERTEX_C = 2'd2,
        REG_MIN_DIST = 2'd3
    } rti_reg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } rti_qstat_t;

    // common factor width: coordinate differences and direction components
    function automatic int rti_fw(int cw);
        return (cw + 1 > DIR_W) ? cw + 1 : DIR_W;
    endfunction

    // width of determinant and numerator sums
    function automatic int rti_sw(int cw);
        return 3 * rti_fw(cw) + 3;
    endfunction

    // queue entry: candidate flag, |den|, |nt|, origin, direction
    function automatic int rti_qw(int cw);
        return 1 + 2 * rti_sw(cw) + 3 * cw + 3 * DIR_W;
    endfunction

endpackage

`default_nettype wire

>>> src/rti_front.sv
// Front end: accepts rays, solves the Cramer determinants and classifies hit candidates.
// Depends on rti_pkg.
`default_nettype none

module rti_front #(
    parameter int CW = 21
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [3*CW-1:0]                       origin,
    input  logic [3*rti_pkg::DIR_W-1:0]           dir,
    input  logic [3*CW-1:0]                       vtx_a,
    input  logic [3*CW-1:0]                       vtx_b,
    input  logic [3*CW-1:0]                       vtx_c,
    input  rti_pkg::rti_qstat_t                   qstat,
    output logic                                  q_push,
    output logic [rti_pkg::rti_qw(CW)-1:0]        q_data
);
    import rti_pkg::*;

    localparam int FW   = rti_fw(CW);
    localparam int MW   = 2 * FW + 1;
    localparam int PW   = FW + MW;
    localparam int SW   = rti_sw(CW);
    localparam int OD_W = 3 * CW + 3 * DIR_W;
    localparam int NS   = 6;

    logic                 en;
    logic [NS-1:0]        v_reg;
    logic [OD_W-1:0]      od_reg [NS];

    logic signed [FW-1:0]   e1_reg [3];
    logic signed [FW-1:0]   e2_reg [3];
    logic signed [FW-1:0]   r_reg  [3];
    logic signed [FW-1:0]   d_reg  [3];
    logic signed [2*FW-1:0] pr_reg [12];
    logic signed [FW-1:0]   f2_reg [4];
    logic signed [FW-1:0]   f3_reg [4];
    logic signed [MW-1:0]   c_reg  [6];
    logic signed [PW-1:0]   t_reg  [12];
    logic signed [SW-1:0]   den_reg, nb_reg, ng_reg, nt_reg;
    logic [rti_qw(CW)-1:0]  q_data_reg;

    logic                   neg;
    logic signed [SW-1:0]   dn, nbn, ngn, ntn;
    logic signed [SW:0]     bsum;
    logic                   cand;

    function automatic logic signed [FW-1:0] vcoord(logic [3*CW-1:0] v, int i);
        return FW'(signed'(v[(2-i)*CW +: CW]));
    endfunction

    // whole pipe moves together; it only holds when the queue is full
    assign en      = !v_reg[NS-1] || !qstat.full;
    assign s_ready = en;
    assign q_push  = v_reg[NS-1] && !qstat.full;
    assign q_data  = q_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NS-2:0], s_valid};
        end
    end

    // edge vectors, origin offset
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                e1_reg[i] <= vcoord(vtx_a, i) - vcoord(vtx_b, i);
                e2_reg[i] <= vcoord(vtx_a, i) - vcoord(vtx_c, i);
                r_reg[i]  <= vcoord(vtx_a, i) - FW'(signed'(origin[i*CW +: CW]));
                d_reg[i]  <= FW'(signed'(dir[i*DIR_W +: DIR_W]));
            end
            od_reg[0] <= {dir, origin};
            for (int k = 1; k < NS; k++) begin
                od_reg[k] <= od_reg[k-1];
            end
        end
    end

    // 2x2 minors: products
    always_ff @(posedge aclk) begin
        if (en) begin
            pr_reg[0]  <= e2_reg[1] * d_reg[2];
            pr_reg[1]  <= d_reg[1]  * e2_reg[2];
            pr_reg[2]  <= r_reg[1]  * d_reg[2];
            pr_reg[3]  <= d_reg[1]  * r_reg[2];
            pr_reg[4]  <= e2_reg[1] * r_reg[2];
            pr_reg[5]  <= r_reg[1]  * e2_reg[2];
            pr_reg[6]  <= d_reg[1]  * e1_reg[2];
            pr_reg[7]  <= e1_reg[1] * d_reg[2];
            pr_reg[8]  <= e1_reg[1] * e2_reg[2];
            pr_reg[9]  <= e2_reg[1] * e1_reg[2];
            pr_reg[10] <= e1_reg[1] * r_reg[2];
            pr_reg[11] <= r_reg[1]  * e1_reg[2];
            f2_reg[0]  <= e1_reg[0];
            f2_reg[1]  <= e2_reg[0];
            f2_reg[2]  <= r_reg[0];
            f2_reg[3]  <= d_reg[0];
        end
    end

    // minors m, n, p, q, s, r
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 6; k++) begin
                c_reg[k] <= MW'(pr_reg[2*k]) - MW'(pr_reg[2*k+1]);
            end
            f3_reg <= f2_reg;
        end
    end

    // x-column products; f3: e1x, e2x, rx, dx   c: m, n, p, q, s, r
    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg[0]  <= f3_reg[0] * c_reg[0];
            t_reg[1]  <= f3_reg[1] * c_reg[3];
            t_reg[2]  <= f3_reg[3] * c_reg[4];
            t_reg[3]  <= f3_reg[2] * c_reg[0];
            t_reg[4]  <= f3_reg[1] * c_reg[1];
            t_reg[5]  <= f3_reg[3] * c_reg[2];
            t_reg[6]  <= f3_reg[0] * c_reg[1];
            t_reg[7]  <= f3_reg[2] * c_reg[3];
            t_reg[8]  <= f3_reg[3] * c_reg[5];
            t_reg[9]  <= f3_reg[0] * c_reg[2];
            t_reg[10] <= f3_reg[1] * c_reg[5];
            t_reg[11] <= f3_reg[2] * c_reg[4];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg <= SW'(t_reg[0]) + SW'(t_reg[1]) + SW'(t_reg[2]);
            nb_reg  <= SW'(t_reg[3]) - SW'(t_reg[4]) - SW'(t_reg[5]);
            ng_reg  <= SW'(t_reg[6]) + SW'(t_reg[7]) + SW'(t_reg[8]);
            nt_reg  <= SW'(t_reg[9]) - SW'(t_reg[10]) + SW'(t_reg[11]);
        end
    end

    // normalize to a positive determinant, then the barycentric tests
    always_comb begin
        neg  = den_reg[SW-1];
        dn   = neg ? -den_reg : den_reg;
        nbn  = neg ? -nb_reg  : nb_reg;
        ngn  = neg ? -ng_reg  : ng_reg;
        ntn  = neg ? -nt_reg  : nt_reg;
        bsum = (SW+1)'(nbn) + (SW+1)'(ngn);
        cand = (den_reg != '0) && !nbn[SW-1] && !ngn[SW-1] && !ntn[SW-1]
               && (bsum < (SW+1)'(dn));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_data_reg <= {cand, dn, ntn, od_reg[NS-2]};
        end
    end

endmodule

`default_nettype wire

>>> src/rti_queue.sv
// Short queue between the front end and the divide / hit-point back end.
// Depends on rti_pkg and the assertion macro header.
`default_nettype none
`include "ray_triangle_intersect_core_macros.svh"

module rti_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 pop,
    output logic [WIDTH-1:0]     rdata,
    output rti_pkg::rti_qstat_t  qstat
);
    import rti_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign qstat.full  = (count_reg == CNT_W'(DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign rdata       = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)  rd_ptr_reg <= bump(rd_ptr_reg);
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= wdata;
    end

    `RTI_ASSERT_IMPL(a_q_no_overflow, aclk, aresetn, push, !qstat.full)
    `RTI_ASSERT_IMPL(a_q_no_underflow, aclk, aresetn, pop, !qstat.empty)
    `RTI_ASSERT_IMPL(a_q_count_range, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH))
    `RTI_ASSERT_NEXT(a_q_count_up, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

`default_nettype wire

>>> src/rti_back.sv
// Back end: bit-per-stage distance divider, min-distance test and saturated hit point.
// Depends on rti_pkg.
`default_nettype none

module rti_back #(
    parameter int CW  = 21,
    parameter int DFB = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  rti_pkg::rti_qstat_t               qstat,
    output logic                              q_pop,
    input  logic [rti_pkg::rti_qw(CW)-1:0]    q_data,
    input  logic [rti_pkg::DIST_W-1:0]        min_dist,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_hit,
    output logic [rti_pkg::DIST_W-1:0]        m_dist,
    output logic [3*CW-1:0]                   m_point
);
    import rti_pkg::*;

    localparam int SW   = rti_sw(CW);
    localparam int OD_W = 3 * CW + 3 * DIR_W;
    localparam int SH   = DIR_FRAC - COORD_FRAC + DFB;
    localparam int MAXS = (SH > DIST_W) ? SH : DIST_W;
    localparam int RW   = SW + MAXS;
    localparam int NDV  = DIST_W + 1;          // entry stage plus one stage per quotient bit
    localparam int NB   = DIST_W + 3;
    localparam int PMW  = DIST_W + 1 + DIR_W;
    localparam int PSW  = PMW + 1;
    localparam logic signed [PSW-1:0] PMAX = PSW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [PSW-1:0] PMIN = -PMAX - PSW'(1);

    logic                en;
    logic [NB-1:0]       val_reg;
    logic [RW-1:0]       rem_reg  [NDV];
    logic [DIST_W-1:0]   q_reg    [NDV];
    logic [SW-1:0]       den_reg  [NDV];
    logic                cand_reg [NDV];
    logic                ovf_reg  [NDV];
    logic [OD_W-1:0]     od_reg   [NDV];

    logic                     in_cand;
    logic [SW-1:0]            in_den, in_nt;
    logic [OD_W-1:0]          in_od;
    logic [RW-1:0]            in_rem;

    logic [DIST_W-1:0]        t_fin;
    logic                     hit_fin;
    logic signed [PMW-1:0]    pm_reg [3];
    logic                     hit_t_reg;
    logic [DIST_W-1:0]        t_t_reg;
    logic [3*CW-1:0]          o_t_reg;

    logic                     m_hit_reg;
    logic [DIST_W-1:0]        m_dist_reg;
    logic [3*CW-1:0]          m_point_reg;
    logic signed [PSW-1:0]    sv [3];
    logic [3*CW-1:0]          pt;

    assign en      = !val_reg[NB-1] || m_ready;
    assign q_pop   = en && !qstat.empty;
    assign m_valid = val_reg[NB-1];
    assign m_hit   = m_hit_reg;
    assign m_dist  = m_dist_reg;
    assign m_point = m_point_reg;

    assign {in_cand, in_den, in_nt, in_od} = q_data;
    assign in_rem = RW'(in_nt) << SH;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg <= '0;
        end else if (en) begin
            val_reg <= {val_reg[NB-2:0], q_pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= in_rem;
            q_reg[0]    <= '0;
            den_reg[0]  <= in_den;
            cand_reg[0] <= in_cand;
            ovf_reg[0]  <= in_rem >= (RW'(in_den) << DIST_W);
            od_reg[0]   <= in_od;
        end
    end

    // restoring divide, most significant quotient bit first
    for (genvar k = 1; k < NDV; k++) begin : g_div
        localparam int B = DIST_W - k;
        logic [RW-1:0] sh;
        logic          ge;
        assign sh = RW'(den_reg[k-1]) << B;
        assign ge = rem_reg[k-1] >= sh;
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? rem_reg[k-1] - sh : rem_reg[k-1];
                q_reg[k]    <= q_reg[k-1] | (DIST_W'(ge) << B);
                den_reg[k]  <= den_reg[k-1];
                cand_reg[k] <= cand_reg[k-1];
                ovf_reg[k]  <= ovf_reg[k-1];
                od_reg[k]   <= od_reg[k-1];
            end
        end
    end

    assign t_fin   = ovf_reg[NDV-1] ? '1 : q_reg[NDV-1];
    assign hit_fin = cand_reg[NDV-1] && (t_fin >= min_dist);

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                pm_reg[i] <= signed'({1'b0, t_fin}) *
                             signed'(od_reg[NDV-1][3*CW + i*DIR_W +: DIR_W]);
            end
            hit_t_reg <= hit_fin;
            t_t_reg   <= t_fin;
            o_t_reg   <= od_reg[NDV-1][3*CW-1:0];
        end
    end

    // floor to Q12.8, add origin, clamp
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sv[i] = PSW'(pm_reg[i] >>> SH) + PSW'(signed'(o_t_reg[i*CW +: CW]));
            if (sv[i] > PMAX)      pt[i*CW +: CW] = PMAX[CW-1:0];
            else if (sv[i] < PMIN) pt[i*CW +: CW] = PMIN[CW-1:0];
            else                   pt[i*CW +: CW] = sv[i][CW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_hit_reg   <= hit_t_reg;
            m_dist_reg  <= hit_t_reg ? t_t_reg : '0;
            m_point_reg <= hit_t_reg ? pt : '0;
        end
    end

endmodule

`default_nettype wire

>>> src/ray_triangle_intersect_core.sv
// Channel    Dir  Fields (lowest bit up)
// s_axis     in   tdata: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
// m_axis     out  tdata: hit_distance, point_x, point_y, point_z; tuser: is_hit
// cfg        in   cfg_addr selects vertex_a, vertex_b, vertex_c, min_distance
//
// One ray per cycle sustained while m_tready stays high
// (6 front stages, 1 in the queue, 33 back stages incl. a 30-stage divider).
// aresetn is synchronous; it empties the pipes and loads the reset vertices.
// A stalled m_tready holds the back end; the 4-entry queue keeps the front taking rays until it fills.
// Depends on rti_pkg, rti_front, rti_queue, rti_back and the macro header.
`default_nettype none
`include "ray_triangle_intersect_core_macros.svh"

module ray_triangle_intersect_core #(
    parameter int COORD_WIDTH    = 21,
    parameter int DIST_FRAC_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, zero pad
    input  logic [((3*COORD_WIDTH+3*rti_pkg::DIR_W+7)/8)*8-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // hit_distance, point_x, point_y, point_z, zero pad
    output logic [((rti_pkg::DIST_W+3*COORD_WIDTH+7)/8)*8-1:0]  m_tdata,
    // is_hit
    output logic                         m_tuser,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_addr,
    input  logic [3*COORD_WIDTH-1:0]     cfg_wdata
);
    import rti_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int VW     = 3 * CW;
    localparam int QW     = rti_qw(CW);
    localparam int OUT_TW = ((DIST_W + 3 * CW + 7) / 8) * 8;

    logic [VW-1:0]     vertex_a_reg, vertex_b_reg, vertex_c_reg;
    logic [DIST_W-1:0] min_dist_reg;

    rti_qstat_t        qstat;
    logic              q_push, q_pop;
    logic [QW-1:0]     q_wdata, q_rdata;
    logic              m_hit;
    logic [DIST_W-1:0] m_dist;
    logic [3*CW-1:0]   m_point;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_a_reg <= '0;
            vertex_b_reg <= VW'(1) << COORD_FRAC;
            vertex_c_reg <= VW'(1) << (2 * CW + COORD_FRAC);
            min_dist_reg <= DIST_W'(MIN_DIST_RST);
        end else if (cfg_we) begin
            case (rti_reg_t'(cfg_addr))
                REG_VERTEX_A: vertex_a_reg <= cfg_wdata;
                REG_VERTEX_B: vertex_b_reg <= cfg_wdata;
                REG_VERTEX_C: vertex_c_reg <= cfg_wdata;
                REG_MIN_DIST: min_dist_reg <= cfg_wdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    rti_front #(.CW(CW)) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .origin  (s_tdata[3*CW-1:0]),
        .dir     (s_tdata[3*CW +: 3*DIR_W]),
        .vtx_a   (vertex_a_reg),
        .vtx_b   (vertex_b_reg),
        .vtx_c   (vertex_c_reg),
        .qstat   (qstat),
        .q_push  (q_push),
        .q_data  (q_wdata)
    );

    rti_queue #(.WIDTH(QW), .DEPTH(QDEPTH)) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .qstat   (qstat)
    );

    rti_back #(.CW(CW), .DFB(DIST_FRAC_BITS)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .qstat    (qstat),
        .q_pop    (q_pop),
        .q_data   (q_rdata),
        .min_dist (min_dist_reg),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_hit    (m_hit),
        .m_dist   (m_dist),
        .m_point  (m_point)
    );

    assign m_tdata = OUT_TW'({m_point, m_dist});
    assign m_tuser = m_hit;

    `RTI_ASSERT_IMPL(a_miss_is_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata == '0)
    `RTI_ASSERT_IMPL(a_hit_min_dist, aclk, aresetn, m_tvalid && m_tuser, m_dist >= min_dist_reg)
    `RTI_ASSERT_IMPL(a_empty_after_rst, aclk, aresetn, $past(!aresetn), !m_tvalid)

endmodule

`default_nettype wire
